### rtl/gdad_pkg.sv
`timescale 1ns / 1ps

package gdad_pkg;

   localparam int unsigned DayW   = 5;
   localparam int unsigned MonthW = 4;
   localparam int unsigned YearW  = 14;
   localparam int unsigned CountW = 16;
   localparam int unsigned SumW   = 17;   // day + count
   localparam int unsigned QuotW  = 9;    // year / 25 for years up to 9999
   localparam int unsigned RemW   = 5;    // year % 25

   localparam logic [YearW-1:0]  YEAR_MAX   = 14'd9999;
   localparam logic [YearW-1:0]  YEAR_RESET = 14'd2000;
   localparam logic [DayW-1:0]   DAY_RESET  = 5'd1;
   localparam logic [MonthW-1:0] MONTH_JAN  = 4'd1;
   localparam logic [MonthW-1:0] MONTH_FEB  = 4'd2;
   localparam logic [MonthW-1:0] MONTH_DEC  = 4'd12;
   localparam logic [RemW-1:0]   REM_RESET  = 5'd0;   // 2000 % 25
   localparam logic [RemW-1:0]   REM_LAST   = 5'd24;

   // ceil(2^17 / 25): exact floor(y / 25) for y up to 9999
   localparam logic [12:0] RECIP25     = 13'd5243;
   localparam int unsigned RECIP_SHIFT = 17;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_LMUL = 5'b00010,
      ST_LREM = 5'b00100,
      ST_WALK = 5'b01000,
      ST_PUB  = 5'b10000
   } state_type;

   typedef struct packed {
      logic take;    // capture the item at the input transfer
      logic lmul;    // year * reciprocal
      logic lrem;    // year % 25
      logic walk;    // one month step or final commit
      logic pub;     // load the result register
   } cmd_type;

   typedef struct packed {
      logic is_load;
      logic load_ok;
      logic more;    // remaining days exceed the current month
   } sts_type;

   function automatic logic [DayW-1:0] days_in(input logic [MonthW-1:0] month,
                                               input logic leap);
      logic [DayW-1:0] len;
      case (month)
         MONTH_FEB: len = leap ? 5'd29 : 5'd28;
         4'd4:      len = 5'd30;
         4'd6:      len = 5'd30;
         4'd9:      len = 5'd30;
         4'd11:     len = 5'd30;
         default:   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

### rtl/gregorian_date_add_days.sv
`timescale 1ns / 1ps

// channel  | direction | handshake            | payload
// req      | in        | req_valid/req_stall  | opcode, add_count, load_day/month/year
// rsp      | out       | rsp_valid/rsp_stall  | cur_day, cur_month, cur_year, flags
//
// Sequencing: one item at a time. A valid load passes through the multiply
//   and remainder states to rebuild year mod 25 before publish, a rejected
//   load goes straight to publish, and an add walks one month per cycle
//   over the months crossed, then commits the day and publishes.
// Reset: date returns to 1 January 2000, both channels go idle.
// Stalls: the result sits in its own register, so the next item is taken
//   while it waits; a finished item holds in the publish state until the
//   result register frees up.

module gregorian_date_add_days (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_opcode,
   input  logic [gdad_pkg::CountW-1:0] req_add_count,
   input  logic [gdad_pkg::DayW-1:0]   req_load_day,
   input  logic [gdad_pkg::MonthW-1:0] req_load_month,
   input  logic [gdad_pkg::YearW-1:0]  req_load_year,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [gdad_pkg::DayW-1:0]   rsp_cur_day,
   output logic [gdad_pkg::MonthW-1:0] rsp_cur_month,
   output logic [gdad_pkg::YearW-1:0]  rsp_cur_year,
   output logic                        rsp_bad_load,
   output logic                        rsp_year_overflow
);

   gdad_pkg::cmd_type cmd;   // controller -> datapath
   gdad_pkg::sts_type sts;   // datapath -> controller

   // sequencer: accept, year-mod-25 rebuild, month walk, publish
   gdad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // date registers, month length lookup, one-month step, result register
   gdad_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_opcode        (req_opcode),
      .req_add_count     (req_add_count),
      .req_load_day      (req_load_day),
      .req_load_month    (req_load_month),
      .req_load_year     (req_load_year),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_cur_day       (rsp_cur_day),
      .rsp_cur_month     (rsp_cur_month),
      .rsp_cur_year      (rsp_cur_year),
      .rsp_bad_load      (rsp_bad_load),
      .rsp_year_overflow (rsp_year_overflow)
   );

endmodule

### rtl/gdad_ctrl.sv
`timescale 1ns / 1ps

module gdad_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  gdad_pkg::sts_type sts,
   output gdad_pkg::cmd_type cmd
);

   gdad_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != gdad_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         gdad_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               if (!sts.is_load)      state_in = gdad_pkg::ST_WALK;
               else if (sts.load_ok)  state_in = gdad_pkg::ST_LMUL;
               else                   state_in = gdad_pkg::ST_PUB;
            end
         end
         gdad_pkg::ST_LMUL: begin
            cmd.lmul = 1'b1;
            state_in = gdad_pkg::ST_LREM;
         end
         gdad_pkg::ST_LREM: begin
            cmd.lrem = 1'b1;
            state_in = gdad_pkg::ST_PUB;
         end
         gdad_pkg::ST_WALK: begin
            cmd.walk = 1'b1;
            if (!sts.more) state_in = gdad_pkg::ST_PUB;
         end
         gdad_pkg::ST_PUB: begin
            if (out_free) begin
               cmd.pub  = 1'b1;
               state_in = gdad_pkg::ST_IDLE;
            end
         end
         default: state_in = gdad_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.pub)          rsp_valid_in = 1'b1;
      else if (!rsp_stall)  rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gdad_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/gdad_dp.sv
`timescale 1ns / 1ps

module gdad_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_opcode,
   input  logic [gdad_pkg::CountW-1:0]       req_add_count,
   input  logic [gdad_pkg::DayW-1:0]         req_load_day,
   input  logic [gdad_pkg::MonthW-1:0]       req_load_month,
   input  logic [gdad_pkg::YearW-1:0]        req_load_year,
   input  gdad_pkg::cmd_type                 cmd,
   output gdad_pkg::sts_type                 sts,
   output logic [gdad_pkg::DayW-1:0]         rsp_cur_day,
   output logic [gdad_pkg::MonthW-1:0]       rsp_cur_month,
   output logic [gdad_pkg::YearW-1:0]        rsp_cur_year,
   output logic                              rsp_bad_load,
   output logic                              rsp_year_overflow
);

   // date state
   logic [gdad_pkg::DayW-1:0]   day_ff, day_in;
   logic [gdad_pkg::MonthW-1:0] month_ff, month_in;
   logic [gdad_pkg::YearW-1:0]  year_ff, year_in;
   logic [gdad_pkg::RemW-1:0]   rem_ff, rem_in;     // year % 25
   // working registers
   logic [gdad_pkg::SumW-1:0]   days_ff, days_in;
   logic [gdad_pkg::QuotW-1:0]  quot_ff, quot_in;
   logic                        bad_ff, bad_in;
   logic                        ovf_ff, ovf_in;
   // result register
   logic [gdad_pkg::DayW-1:0]   out_day_ff;
   logic [gdad_pkg::MonthW-1:0] out_month_ff;
   logic [gdad_pkg::YearW-1:0]  out_year_ff;
   logic                        out_bad_ff, out_ovf_ff;

   logic                        leap;
   logic [gdad_pkg::DayW-1:0]   len;
   logic [gdad_pkg::YearW-1:0]  sat_year;
   logic [25:0]                 prod;
   logic [gdad_pkg::YearW-1:0]  quot25;
   logic [gdad_pkg::YearW-1:0]  rem_full;
   logic                        load_ok;

   // leap: y%4 == 0 and (y%100 != 0 or y%400 == 0); with y%4 == 0,
   // y%100 == 0 means y%25 == 0 and y%400 == 0 means also y%16 == 0
   assign leap = (year_ff[1:0] == 2'd0) &&
                 ((rem_ff != '0) || (year_ff[3:0] == 4'd0));
   assign len  = gdad_pkg::days_in(month_ff, leap);

   assign load_ok  = (req_load_month >= gdad_pkg::MONTH_JAN) &&
                     (req_load_month <= gdad_pkg::MONTH_DEC);
   assign sat_year = (req_load_year > gdad_pkg::YEAR_MAX) ? gdad_pkg::YEAR_MAX
                                                          : req_load_year;

   assign prod     = {12'b0, year_ff} * {13'b0, gdad_pkg::RECIP25};
   assign quot25   = {1'b0, quot_ff, 4'b0} + {2'b0, quot_ff, 3'b0} + {5'b0, quot_ff};
   assign rem_full = year_ff - quot25;

   assign sts.is_load = (req_opcode == gdad_pkg::OP_LOAD);
   assign sts.load_ok = load_ok;
   assign sts.more    = (days_ff > {{(gdad_pkg::SumW-gdad_pkg::DayW){1'b0}}, len});

   always_comb begin
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      rem_in   = rem_ff;
      days_in  = days_ff;
      quot_in  = quot_ff;
      bad_in   = bad_ff;
      ovf_in   = ovf_ff;
      if (cmd.take) begin
         days_in = {1'b0, req_add_count} + {{(gdad_pkg::SumW-gdad_pkg::DayW){1'b0}}, day_ff};
         bad_in  = sts.is_load && !load_ok;
         ovf_in  = 1'b0;
         if (sts.is_load && load_ok) begin
            day_in   = req_load_day;
            month_in = req_load_month;
            year_in  = sat_year;
         end
      end
      if (cmd.lmul) quot_in = prod[gdad_pkg::RECIP_SHIFT +: gdad_pkg::QuotW];
      if (cmd.lrem) rem_in  = rem_full[gdad_pkg::RemW-1:0];
      if (cmd.walk) begin
         if (sts.more) begin
            days_in = days_ff - {{(gdad_pkg::SumW-gdad_pkg::DayW){1'b0}}, len};
            if (month_ff == gdad_pkg::MONTH_DEC) begin
               month_in = gdad_pkg::MONTH_JAN;
               if (year_ff >= gdad_pkg::YEAR_MAX) begin
                  year_in = '0;
                  rem_in  = '0;
                  ovf_in  = 1'b1;
               end else begin
                  year_in = year_ff + 1'b1;
                  rem_in  = (rem_ff == gdad_pkg::REM_LAST) ? '0 : rem_ff + 1'b1;
               end
            end else begin
               month_in = month_ff + 1'b1;
            end
         end else begin
            day_in = days_ff[gdad_pkg::DayW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         day_ff   <= gdad_pkg::DAY_RESET;
         month_ff <= gdad_pkg::MONTH_JAN;
         year_ff  <= gdad_pkg::YEAR_RESET;
         rem_ff   <= gdad_pkg::REM_RESET;
      end else begin
         day_ff   <= day_in;
         month_ff <= month_in;
         year_ff  <= year_in;
         rem_ff   <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      days_ff <= days_in;
      quot_ff <= quot_in;
      bad_ff  <= bad_in;
      ovf_ff  <= ovf_in;
      if (cmd.pub) begin
         out_day_ff   <= day_ff;
         out_month_ff <= month_ff;
         out_year_ff  <= year_ff;
         out_bad_ff   <= bad_ff;
         out_ovf_ff   <= ovf_ff;
      end
   end

   assign rsp_cur_day       = out_day_ff;
   assign rsp_cur_month     = out_month_ff;
   assign rsp_cur_year      = out_year_ff;
   assign rsp_bad_load      = out_bad_ff;
   assign rsp_year_overflow = out_ovf_ff;

endmodule

### rtl/gdad_checker.sv
`timescale 1ns / 1ps

module gdad_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [gdad_pkg::DayW-1:0]   rsp_cur_day,
   input logic [gdad_pkg::MonthW-1:0] rsp_cur_month,
   input logic [gdad_pkg::YearW-1:0]  rsp_cur_year,
   input logic                        rsp_bad_load,
   input logic                        rsp_year_overflow
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cur_day) &&
         $stable(rsp_cur_month) && $stable(rsp_cur_year) &&
         $stable(rsp_bad_load) && $stable(rsp_year_overflow))
      else $error("result changed while stalled");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cur_month >= gdad_pkg::MONTH_JAN &&
                    rsp_cur_month <= gdad_pkg::MONTH_DEC)
      else $error("month out of range");

   a_year_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cur_year <= gdad_pkg::YEAR_MAX)
      else $error("year out of range");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_bad_load && rsp_year_overflow))
      else $error("load error and overflow together");

   // a wrap leaves at most 65566 days, well under 200 years
   a_wrap_year: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_year_overflow |-> rsp_cur_year < 14'd200)
      else $error("year too large after wrap");

endmodule

bind gregorian_date_add_days gdad_checker u_gdad_checker (.*);

### bench/gregorian_date_add_days_tb.sv
`timescale 1ns / 1ps

// Checks the calendar date block against a cycle-free model of the date
// register: every transfer on the request side updates the model date and
// queues the date due back; every transfer on the result side is compared
// field by field with the oldest queued date.

module gregorian_date_add_days_tb;

   localparam int unsigned DayW   = gdad_pkg::DayW;
   localparam int unsigned MonthW = gdad_pkg::MonthW;
   localparam int unsigned YearW  = gdad_pkg::YearW;
   localparam int unsigned CountW = gdad_pkg::CountW;

   localparam logic [YearW-1:0]  YEAR_MAX   = gdad_pkg::YEAR_MAX;
   localparam logic [YearW-1:0]  YEAR_RESET = gdad_pkg::YEAR_RESET;
   localparam logic [DayW-1:0]   DAY_RESET  = gdad_pkg::DAY_RESET;
   localparam logic [MonthW-1:0] MONTH_JAN  = gdad_pkg::MONTH_JAN;
   localparam logic              OP_ADD     = gdad_pkg::OP_ADD;
   localparam logic              OP_LOAD    = gdad_pkg::OP_LOAD;

   // slowest legal run: ~270 items, each with a full-range month walk plus the
   //    longest stall and gap bursts, taken about four times over
   localparam int CYCLE_LIMIT = 2_500_000;
   localparam int DRAIN_CYCLES = 20;   // settle time once nothing is due

   // month lengths outside February, indexed by month number
   localparam int MONTH_DAYS [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   typedef struct {
      logic [DayW-1:0]   day;
      logic [MonthW-1:0] month;
      logic [YearW-1:0]  year;
      logic              bad_load;
      logic              year_overflow;
   } date_result_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_opcode;
   logic [CountW-1:0]   req_add_count;
   logic [DayW-1:0]     req_load_day;
   logic [MonthW-1:0]   req_load_month;
   logic [YearW-1:0]    req_load_year;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [DayW-1:0]     rsp_cur_day;
   logic [MonthW-1:0]   rsp_cur_month;
   logic [YearW-1:0]    rsp_cur_year;
   logic                rsp_bad_load;
   logic                rsp_year_overflow;

   // model date, as the block should hold it after each accepted transfer
   logic [DayW-1:0]     model_day   = DAY_RESET;
   logic [MonthW-1:0]   model_month = MONTH_JAN;
   logic [YearW-1:0]    model_year  = YEAR_RESET;

   date_result_type     dates_due[$];
   int                  mismatches  = 0;
   int                  cycle_count = 0;
   bit                  quiet       = 1'b0;   // no idling on either side

   gregorian_date_add_days u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_add_count     (req_add_count),
      .req_load_day      (req_load_day),
      .req_load_month    (req_load_month),
      .req_load_year     (req_load_year),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cur_day       (rsp_cur_day),
      .rsp_cur_month     (rsp_cur_month),
      .rsp_cur_year      (rsp_cur_year),
      .rsp_bad_load      (rsp_bad_load),
      .rsp_year_overflow (rsp_year_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Date model
   // ---------------------------------------------------------------

   function automatic bit leap_year(input int yr);
      return ((yr % 4) == 0 && (yr % 100) != 0) || ((yr % 400) == 0);
   endfunction

   function automatic int month_length(input int mon, input int yr);
      if (mon < 1 || mon > 12) return 31;
      if (mon == 2) return leap_year(yr) ? 29 : 28;
      return MONTH_DAYS[mon];
   endfunction

   // Applies one accepted request to the model date and queues the result.
   task automatic advance_date(input logic op, input logic [CountW-1:0] count,
                               input logic [DayW-1:0] ld, input logic [MonthW-1:0] lm,
                               input logic [YearW-1:0] ly);
      date_result_type due;
      int              days;
      int              mon;
      int              yr;
      due.bad_load      = 1'b0;
      due.year_overflow = 1'b0;
      if (op == OP_LOAD) begin
         if (lm >= 1 && lm <= 12) begin
            model_day   = ld;
            model_month = lm;
            model_year  = (ly > YEAR_MAX) ? YEAR_MAX : ly;
         end else begin
            due.bad_load = 1'b1;   // date left as it was
         end
      end else begin
         // add: walk month by month while the day overruns the month
         days = int'(model_day) + int'(count);
         mon  = model_month;
         yr   = model_year;
         while (days > month_length(mon, yr)) begin
            days -= month_length(mon, yr);
            mon++;
            if (mon > 12) begin
               mon = 1;
               if (yr >= int'(YEAR_MAX)) begin
                  yr = 0;
                  due.year_overflow = 1'b1;
               end else begin
                  yr++;
               end
            end
         end
         model_day   = days[DayW-1:0];
         model_month = mon[MonthW-1:0];
         model_year  = yr[YearW-1:0];
      end
      due.day   = model_day;
      due.month = model_month;
      due.year  = model_year;
      dates_due.push_back(due);
   endtask

   // ---------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------

   // Drives one request from a falling edge, possibly after an idle burst,
   // and holds it until a rising edge without stall takes it.
   task automatic send_item(input logic op, input logic [CountW-1:0] count,
                            input logic [DayW-1:0] ld, input logic [MonthW-1:0] lm,
                            input logic [YearW-1:0] ly);
      int gap;
      gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_opcode     = op;
      req_add_count  = count;
      req_load_day   = ld;
      req_load_month = lm;
      req_load_year  = ly;
      do @(posedge clock); while (req_stall);
      advance_date(op, count, ld, lm, ly);
   endtask

   // unused fields carry random bits so they toggle on every kind of item
   task automatic load_date(input int d, input int m, input int y);
      send_item(OP_LOAD, CountW'($urandom), DayW'(d), MonthW'(m), YearW'(y));
   endtask

   task automatic add_days(input int n);
      send_item(OP_ADD, CountW'(n), DayW'($urandom), MonthW'($urandom),
                YearW'($urandom));
   endtask

   // mostly short hops; the odd full-range count makes the long month walks
   function automatic int pick_count();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6) return $urandom_range(0, 62);
      if (sel < 9) return $urandom_range(0, 1500);
      return $urandom_range(0, 65535);
   endfunction

   function automatic int pick_year();
      int sel;
      sel = $urandom_range(0, 7);
      case (sel)
         0:       return $urandom_range(9995, 9999);      // near the wrap
         1:       return $urandom_range(0, 16383);        // incl. saturation
         2:       return 400 * $urandom_range(0, 24);      // centuries
         default: return $urandom_range(0, 9999);
      endcase
   endfunction

   // loads are spread over every day and month value, bad months included
   task automatic send_random_item();
      int m;
      if ($urandom_range(0, 9) < 4) begin
         m = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
         load_date($urandom_range(0, 31), m, pick_year());
      end else begin
         add_days(pick_count());
      end
   endtask

   // ---------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------

   // stall in bursts, changed only at falling edges
   initial begin : stall_gen
      int burst;
      burst     = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (burst > 0) begin
            burst--;
            rsp_stall = 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            burst     = $urandom_range(0, 7);
            rsp_stall = 1'b1;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : check_rsp
      date_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (dates_due.size() == 0) begin
            $display("%0t: result with none due, expected nothing, actual %0d/%0d/%0d",
                     $time, rsp_cur_day, rsp_cur_month, rsp_cur_year);
            mismatches++;
         end else begin
            want = dates_due.pop_front();
            check_field("cur_day", want.day, rsp_cur_day);
            check_field("cur_month", want.month, rsp_cur_month);
            check_field("cur_year", want.year, rsp_cur_year);
            check_field("bad_load", want.bad_load, rsp_bad_load);
            check_field("year_overflow", want.year_overflow, rsp_year_overflow);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still due", $time, dates_due.size());
         $display("gregorian_date_add_days_tb: FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // date straight out of reset, read back by adding nothing
   task automatic test_reset_date();
      add_days(0);
   endtask

   // extremes of the load fields, year saturation, rejected months
   task automatic test_loads();
      load_date(31, 12, 9999);
      load_date(1, 1, 0);
      load_date(15, 6, 16383);   // saturates to the top year
      load_date(17, 10, 10000);
      load_date(5, 0, 1234);     // bad month: date kept
      load_date(9, 13, 0);
      load_date(30, 15, 8191);
   endtask

   // month ends, leap and non-leap Februaries, a whole year
   task automatic test_month_walk();
      load_date(28, 2, 2000);
      add_days(1);               // 29 Feb in a 400-year
      add_days(1);
      load_date(28, 2, 1900);
      add_days(1);               // century, no 29th
      load_date(31, 1, 2100);
      add_days(29);
      load_date(1, 1, 2024);
      add_days(365);
   endtask

   // day zero survives an add of nothing
   task automatic test_day_zero();
      load_date(0, 5, 2010);
      add_days(0);
      add_days(3);
   endtask

   // day past month end is normalised by the next add
   task automatic test_day_past_end();
      load_date(31, 2, 2001);
      add_days(0);
   endtask

   // December of the top year rolls into year zero
   task automatic test_year_wrap();
      load_date(31, 12, 9999);
      add_days(1);
   endtask

   // largest count, twice, wrapping on the way
   task automatic test_max_count();
      load_date(31, 12, 9998);
      add_days(65535);
      add_days(65535);
   endtask

   task automatic test_random_traffic(input int n);
      repeat (n) send_random_item();
   endtask

   // back-to-back transfers with neither side idling
   task automatic test_back_to_back(input int n);
      quiet = 1'b1;
      repeat (n) send_random_item();
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_opcode     = OP_ADD;
      req_add_count  = '0;
      req_load_day   = '0;
      req_load_month = '0;
      req_load_year  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_date();
      test_loads();
      test_month_walk();
      test_day_zero();
      test_day_past_end();
      test_year_wrap();
      test_max_count();
      test_random_traffic(200);
      test_back_to_back(40);

      @(negedge clock);
      req_valid = 1'b0;
      while (dates_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("gregorian_date_add_days_tb: PASS");
      end else begin
         $display("gregorian_date_add_days_tb: FAIL");
      end
      $finish;
   end

endmodule

### files.f
rtl/gdad_pkg.sv
rtl/gdad_ctrl.sv
rtl/gdad_dp.sv
rtl/gregorian_date_add_days.sv
rtl/gdad_checker.sv
bench/gregorian_date_add_days_tb.sv
